// ===== src/b64dec_pkg.sv =====
// shared types, constants and the character-to-sextet lookup of the base64 decoder
// depends on nothing; imported by the decoder top level and its checker
package b64dec_pkg;

	localparam logic [7:0] PAD_CHAR = 8'h3D;   // '='
	localparam int SEXTET_W = 6;
	localparam int GROUP_SEXTETS_W = 3 * SEXTET_W;
	localparam int RES_QUEUE_DEPTH = 6;        // room for a burst of three behind three queued
	localparam int RES_CNT_W = $clog2(RES_QUEUE_DEPTH + 1);
	localparam int RES_IDX_W = $clog2(RES_QUEUE_DEPTH);
	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       status;
	} result_t;

	typedef struct packed {
		logic                  bad;
		logic [SEXTET_W-1:0]   value;
	} sextet_t;

	// standard alphabet lookup, anything else is flagged bad with value 0
	function automatic sextet_t sextet_of(input logic [7:0] c);
		sextet_t s;
		s.bad = 1'b0;
		s.value = '0;
		case (c) inside
			[8'h41:8'h5A]: s.value = SEXTET_W'(c - 8'h41);
			[8'h61:8'h7A]: s.value = SEXTET_W'(c - 8'h61 + 8'd26);
			[8'h30:8'h39]: s.value = SEXTET_W'(c - 8'h30 + 8'd52);
			8'h2B:         s.value = SEXTET_W'(62);
			8'h2F:         s.value = SEXTET_W'(63);
			default:       s.bad = 1'b1;
		endcase
		return s;
	endfunction

endpackage

// ===== src/base64_stream_decoder.sv =====
// streaming base64 decoder: input register, group decode logic and result queue
// depends on b64dec_pkg
//
// usage
//   input channel: one character per transfer (in_char, in_last marks the final
//   character of a message). output channel: one decoded byte per transfer with
//   out_last on the final result of the message and out_status 1 for an error result
//   (byte 0, always final). both channels use valid/stall; the receiver drives stall.
// path: a character is registered, then decoded against the group state, and its
//   bytes are written into the result queue at the end of the decode cycle; results
//   show from queue entry 0, the output register.
// throughput: one character per cycle while the queue has room. a full group writes
//   three results at once into a six-entry queue that drains one per cycle; the input
//   stalls only when the queue holds more than three results, so a steady stream never
//   stalls as long as the output is not stalled.
// reset: arst_n clears the group state, the input register and the queue; the next
//   character starts a new message.
// output stall: the queue fills, the decode stage holds its character, and the
//   input channel stalls until room for a whole group burst frees up.
module base64_stream_decoder
	import b64dec_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_char,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       out_status
);

	// input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	// group state
	logic [GROUP_SEXTETS_W-1:0] sextets_q;
	logic [2:0]                 bad_q;
	logic                       pad3_q;
	logic [1:0]                 pos_q;
	logic                       err_q;

	// result queue, entry 0 is the output register
	result_t              queue_q [RES_QUEUE_DEPTH];
	logic [RES_CNT_W-1:0] count_q;

	// decode results
	sextet_t                    cur;
	logic [1:0]                 n_res;
	result_t                    res [3];
	logic [GROUP_SEXTETS_W-1:0] sextets_d;
	logic [2:0]                 bad_d;
	logic                       pad3_d;
	logic [1:0]                 pos_d;
	logic                       err_d;
	logic [5:0]                 v1, v2, v3, v4;
	logic [23:0]                bits;
	logic                       group_bad;

	logic                 push_ok;
	logic                 advance;
	logic                 in_xfer;
	logic                 pop;
	logic [RES_CNT_W-1:0] base;
	logic [RES_IDX_W-1:0] slot;
	result_t              queue_d [RES_QUEUE_DEPTH];

	// stage control
	assign push_ok  = count_q <= RES_CNT_W'(RES_QUEUE_DEPTH - 3);
	assign advance  = valid_s1 && push_ok;
	assign in_stall = valid_s1 && !push_ok;
	assign in_xfer  = in_valid && !in_stall;
	assign pop      = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			char_s1 <= in_char;
			last_s1 <= in_last;
		end
	end

	// group decode against the registered character
	always_comb begin
		cur = sextet_of(char_s1);
		v1 = sextets_q[17:12];
		v2 = sextets_q[11:6];
		v3 = sextets_q[5:0];
		v4 = cur.value;
		group_bad = 1'b0;
		n_res = 2'd0;
		for (int k = 0; k < 3; k++) begin
			res[k] = '{data: 8'h00, last: 1'b0, status: STATUS_OK};
		end
		sextets_d = sextets_q;
		bad_d = bad_q;
		pad3_d = pad3_q;
		pos_d = pos_q;
		err_d = err_q;

		if (err_q) begin
			// swallow the rest of a broken message, report at its end
			if (last_s1) begin
				group_bad = 1'b1;
			end
		end else if (pos_q != 2'd3) begin
			if (last_s1) begin
				group_bad = 1'b1;   // length not a multiple of four
			end else begin
				sextets_d = {sextets_q[11:0], cur.value};
				bad_d = bad_q | (3'(cur.bad) << pos_q);
				if (pos_q == 2'd2) begin
					pad3_d = (char_s1 == PAD_CHAR);
				end
				pos_d = pos_q + 2'd1;
			end
		end else if (!last_s1) begin
			if (bad_q != 3'b000 || cur.bad) begin
				err_d = 1'b1;
			end else begin
				n_res = 2'd3;
			end
		end else if (pad3_q) begin
			// '=' third: one byte, fourth character ignored
			if (bad_q[1:0] != 2'b00) begin
				group_bad = 1'b1;
			end else begin
				v3 = '0;
				v4 = '0;
				n_res = 2'd1;
			end
		end else if (char_s1 == PAD_CHAR) begin
			if (bad_q != 3'b000) begin
				group_bad = 1'b1;
			end else begin
				v4 = '0;
				n_res = 2'd2;
			end
		end else if (bad_q != 3'b000 || cur.bad) begin
			group_bad = 1'b1;
		end else begin
			n_res = 2'd3;
		end

		bits = {v1, v2, v3, v4};
		if (group_bad) begin
			n_res = 2'd1;
			res[0] = '{data: 8'h00, last: 1'b1, status: STATUS_BAD};
		end else begin
			res[0] = '{data: bits[23:16], last: last_s1 && n_res == 2'd1, status: STATUS_OK};
			res[1] = '{data: bits[15:8],  last: last_s1 && n_res == 2'd2, status: STATUS_OK};
			res[2] = '{data: bits[7:0],   last: last_s1,                  status: STATUS_OK};
		end

		// a completed group, an error or a message end restarts the group
		if (pos_q == 2'd3 || err_d != err_q || last_s1) begin
			sextets_d = '0;
			bad_d = '0;
			pad3_d = 1'b0;
			pos_d = 2'd0;
		end
		if (last_s1) begin
			err_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sextets_q <= '0;
			bad_q <= '0;
			pad3_q <= 1'b0;
			pos_q <= 2'd0;
			err_q <= 1'b0;
		end else if (advance) begin
			sextets_q <= sextets_d;
			bad_q <= bad_d;
			pad3_q <= pad3_d;
			pos_q <= pos_d;
			err_q <= err_d;
		end
	end

	// result queue: shift out at entry 0, append behind the remaining entries
	assign base = count_q - RES_CNT_W'(pop);

	always_comb begin
		slot = '0;
		for (int i = 0; i < RES_QUEUE_DEPTH - 1; i++) begin
			queue_d[i] = pop ? queue_q[i+1] : queue_q[i];
		end
		queue_d[RES_QUEUE_DEPTH-1] = queue_q[RES_QUEUE_DEPTH-1];
		for (int k = 0; k < 3; k++) begin
			slot = RES_IDX_W'(base + RES_CNT_W'(k));
			if (advance && k < int'(n_res)) begin
				queue_d[slot] = res[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < RES_QUEUE_DEPTH; i++) begin
			queue_q[i] <= queue_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= base + (advance ? RES_CNT_W'(n_res) : RES_CNT_W'(0));
		end
	end

	assign out_valid  = count_q != '0;
	assign out_byte   = queue_q[0].data;
	assign out_last   = queue_q[0].last;
	assign out_status = queue_q[0].status;

endmodule

// ===== src/b64dec_checker.sv =====
// port-level checks for the base64 decoder and the bind that attaches them
// depends on b64dec_pkg and base64_stream_decoder
module b64dec_checker
	import b64dec_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       out_last,
	input logic       out_status
);

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable({out_byte, out_last, out_status}))
		else $error("stalled result changed");

	// an error result always ends the message
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status == STATUS_BAD |-> out_last)
		else $error("error result without out_last");

	// an error result carries a zero byte
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status == STATUS_BAD |-> out_byte == 8'h00)
		else $error("error result with nonzero byte");

	// input only backs up behind queued results
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result pending");

endmodule

bind base64_stream_decoder b64dec_checker u_b64dec_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.out_byte   (out_byte),
	.out_last   (out_last),
	.out_status (out_status)
);

// ===== test/base64_stream_decoder_tb.sv =====
// self-checking testbench for the streaming base64 decoder
// holds its own group decoder in a small checker class; depends on b64dec_pkg and the rtl
`timescale 1ns / 1ps

module base64_stream_decoder_tb
	import b64dec_pkg::*;
();

	localparam int RANDOM_CHARS = 230;
	localparam int QUIET_TAIL = 50;     // last chars run with no idling on either side
	localparam int LONG_HOLD = 60;      // cycles of receiver hold-off to fill the result queue
	localparam int DRAIN_CYCLES = 12;

	// decoder model and expected byte store
	class decode_checker;
		result_t decoded_fifo[$];
		logic [17:0] sextets;
		logic [2:0] bad_marks;
		logic third_pad;
		logic [1:0] slot;
		logic msg_error;
		int mismatches;

		function new();
			mismatches = 0;
			reset_group();
			msg_error = 1'b0;
		endfunction

		function void reset_group();
			sextets = '0;
			bad_marks = '0;
			third_pad = 1'b0;
			slot = '0;
		endfunction

		// {bad, value}; value is 0 for a character outside the alphabet
		function logic [6:0] sextet_lookup(input logic [7:0] c);
			if (c >= "A" && c <= "Z")
				return {1'b0, 6'(c - "A")};
			if (c >= "a" && c <= "z")
				return {1'b0, 6'(c - "a" + 26)};
			if (c >= "0" && c <= "9")
				return {1'b0, 6'(c - "0" + 52)};
			if (c == "+")
				return {1'b0, 6'd62};
			if (c == "/")
				return {1'b0, 6'd63};
			return {1'b1, 6'd0};
		endfunction

		function void push_byte(input logic [7:0] b, input logic fin, input logic st);
			result_t r;
			r.data = b;
			r.last = fin;
			r.status = st;
			decoded_fifo.push_back(r);
		endfunction

		function void push_error();
			push_byte(8'h00, 1'b1, STATUS_BAD);
			reset_group();
			msg_error = 1'b0;
		endfunction

		// one accepted character transfer
		function void take_char(input logic [7:0] c, input logic fin);
			logic [6:0] sx;
			logic [5:0] v1, v2, v3, v4;
			logic [23:0] bits;
			int n;
			sx = sextet_lookup(c);
			if (msg_error) begin
				if (fin)
					push_error();
				return;
			end
			if (slot != 2'd3) begin
				if (fin) begin
					push_error();
					return;
				end
				sextets = {sextets[11:0], sx[5:0]};
				bad_marks = bad_marks | (3'(sx[6]) << slot);
				if (slot == 2'd2)
					third_pad = (c == PAD_CHAR);
				slot = slot + 2'd1;
				return;
			end
			v1 = sextets[17:12];
			v2 = sextets[11:6];
			v3 = sextets[5:0];
			v4 = sx[5:0];
			if (!fin) begin
				if (bad_marks != 3'b000 || sx[6]) begin
					reset_group();
					msg_error = 1'b1;
					return;
				end
				n = 3;
			end else if (third_pad) begin
				if (bad_marks[1:0] != 2'b00) begin
					push_error();
					return;
				end
				v3 = '0;
				v4 = '0;
				n = 1;
			end else if (c == PAD_CHAR) begin
				if (bad_marks != 3'b000) begin
					push_error();
					return;
				end
				v4 = '0;
				n = 2;
			end else begin
				if (bad_marks != 3'b000 || sx[6]) begin
					push_error();
					return;
				end
				n = 3;
			end
			bits = {v1, v2, v3, v4};
			push_byte(bits[23:16], fin && n == 1, STATUS_OK);
			if (n >= 2)
				push_byte(bits[15:8], fin && n == 2, STATUS_OK);
			if (n >= 3)
				push_byte(bits[7:0], fin, STATUS_OK);
			reset_group();
			if (fin)
				msg_error = 1'b0;
		endfunction

		// one accepted result transfer
		function void compare_byte(input logic [7:0] b, input logic fin, input logic st);
			result_t e;
			if (decoded_fifo.size() == 0) begin
				$display("%0t: unexpected result byte %h last %b status %b", $time, b, fin, st);
				mismatches++;
				return;
			end
			e = decoded_fifo.pop_front();
			if (b !== e.data) begin
				$display("%0t: out_byte expected %h actual %h", $time, e.data, b);
				mismatches++;
			end
			if (fin !== e.last) begin
				$display("%0t: out_last expected %b actual %b", $time, e.last, fin);
				mismatches++;
			end
			if (st !== e.status) begin
				$display("%0t: out_status expected %b actual %b", $time, e.status, st);
				mismatches++;
			end
		endfunction

		function int outstanding();
			return decoded_fifo.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [7:0] in_char;
	logic in_last;
	logic out_valid;
	logic out_stall;
	logic [7:0] out_byte;
	logic out_last;
	logic out_status;

	decode_checker chk;
	bit idle_on = 1'b1;         // random idling on both channels
	bit long_hold_req = 1'b0;   // asks the receiver for one long hold-off
	int chars_sent = 0;

	base64_stream_decoder i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_char    (in_char),
		.in_last    (in_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.out_last   (out_last),
		.out_status (out_status)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// alphabet character for a sextet value
	function automatic logic [7:0] alpha_char(input int idx);
		if (idx < 26)
			return 8'("A" + idx);
		if (idx < 52)
			return 8'("a" + idx - 26);
		if (idx < 62)
			return 8'("0" + idx - 52);
		if (idx == 62)
			return "+";
		return "/";
	endfunction

	// offer one character and wait for its transfer; may idle first
	task automatic send_char(input logic [7:0] c, input logic fin);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_char <= c;
		in_last <= fin;
		do
			@(posedge clk);
		while (in_stall);
		chk.take_char(c, fin);
		chars_sent++;
	endtask

	// send a text, with the last flag on its final character when close is set
	task automatic send_text(input string s, input bit close);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], close && i == s.len() - 1);
	endtask

	// mostly well-formed messages with random content, some broken ones and pure noise
	task automatic send_random_message();
		logic [7:0] msg[$];
		int groups;
		int drop;
		int len;
		groups = $urandom_range(1, 3);
		for (int g = 0; g < groups * 4; g++)
			msg.push_back(alpha_char($urandom_range(0, 63)));
		case ($urandom_range(0, 3))
			1: msg[msg.size() - 1] = PAD_CHAR;
			2: begin
				msg[msg.size() - 2] = PAD_CHAR;
				msg[msg.size() - 1] = PAD_CHAR;
			end
			3: begin
				// fourth character of a '=' third group is don't-care
				msg[msg.size() - 2] = PAD_CHAR;
				msg[msg.size() - 1] = 8'($urandom_range(0, 255));
			end
			default: ;
		endcase
		case ($urandom_range(0, 11))
			0, 1: msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
			2: begin
				drop = $urandom_range(1, 3);
				repeat (drop) void'(msg.pop_back());
			end
			3: msg.push_back(alpha_char($urandom_range(0, 63)));
			4: begin
				len = $urandom_range(1, 9);
				msg.delete();
				repeat (len) msg.push_back(8'($urandom_range(0, 255)));
			end
			5: begin
				// pad inside a group that is not the final one
				if (groups > 1)
					msg[$urandom_range(0, 3)] = PAD_CHAR;
			end
			default: ;
		endcase
		for (int i = 0; i < msg.size(); i++)
			send_char(msg[i], i == msg.size() - 1);
	endtask

	// receiver: checks every result transfer and picks the stall for the next cycle
	initial begin
		int hold_left;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				chk.compare_byte(out_byte, out_last, out_status);
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (long_hold_req) begin
				// long hold-off while the sender keeps offering characters
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD - 1;
				out_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				hold_left = $urandom_range(0, 3);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// stimulus
	initial begin
		int target;
		chk = new();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_char <= 8'h00;
		in_last <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: all-zero bytes, then FF FF BD from slash, plus and digit characters
		send_text("AAAA", 1'b0);
		send_text("//+9", 1'b1);
		// pad third: one byte, fourth character ignored even with the top bit set
		send_text("TQ=", 1'b0);
		send_char(8'hFF, 1'b1);
		// pad fourth only: two bytes
		send_text("TWE=", 1'b1);
		// pad in a group that is not final, then error reported on the last character
		send_text("=AAAz", 1'b1);
		// length errors: last at the first and at the second place of a group
		send_char(8'h00, 1'b1);
		send_char("Z", 1'b0);
		send_char(8'h80, 1'b1);
		// bad final group
		send_text("A=AA", 1'b1);

		// random part, with one long receiver hold-off early on
		long_hold_req = 1'b1;
		target = chars_sent + RANDOM_CHARS;
		while (chars_sent < target) begin
			if (chars_sent >= target - QUIET_TAIL)
				idle_on = 1'b0;
			send_random_message();
		end
		in_valid <= 1'b0;

		while (chk.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (chk.mismatches == 0) begin
			$display("[base64_stream_decoder] OK");
		end else begin
			$display("[base64_stream_decoder] ERROR");
		end
		$finish;
	end

	// run limit
	initial begin
		#200000;
		$display("[base64_stream_decoder] ERROR");
		$finish;
	end

endmodule
